// ----- src/rstg_pkg.sv -----
// Constants shared by the seed table generator, its channel interfaces and its checker.
// No dependencies: this file compiles first.
`timescale 1ns / 1ps
`default_nettype none

package rstg_pkg;

    // Field widths of the channels and registers.
    localparam int SEED_W  = 15;
    localparam int LAG_W   = 8;
    localparam int INDEX_W = 7;
    localparam int VALUE_W = 24;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Shared multiplier: a 15-bit operand by a 9-bit operand.
    localparam int MULX_W = 15;
    localparam int MULY_W = 9;
    localparam int MULP_W = MULX_W + MULY_W;

    localparam logic [INDEX_W-1:0] TABLE_WORDS = 7'd97;

    // Moduli and the seed dividers.
    localparam logic [LAG_W-1:0] LAG_MOD   = 8'd179;
    localparam logic [LAG_W-1:0] CONG_MOD  = 8'd169;
    localparam logic [LAG_W-1:0] SEED1_DIV = 8'd177;
    localparam logic [LAG_W-1:0] SEED2_DIV = 8'd169;
    localparam logic [MULY_W-1:0] CONG_MUL = 9'd53;

    // Reciprocals floor(2^16 / m). The estimate they give is at most one
    // below the true quotient for every operand below 2^15.
    localparam int RECIP_SHIFT = 16;
    localparam logic [MULY_W-1:0] RECIP_179 = 9'd366;
    localparam logic [MULY_W-1:0] RECIP_177 = 9'd370;
    localparam logic [MULY_W-1:0] RECIP_169 = 9'd387;

    // Seed ranges, the fallback pair and the reset values.
    localparam logic [SEED_W-1:0] S1_MAX     = 15'd31328;
    localparam logic [SEED_W-1:0] S2_MAX     = 15'd30081;
    localparam logic [SEED_W-1:0] S1_DEFAULT = 15'd1231;
    localparam logic [SEED_W-1:0] S2_DEFAULT = 15'd7354;
    localparam logic [SEED_W-1:0] S1_RESET   = 15'd17985;
    localparam logic [SEED_W-1:0] S2_RESET   = 15'd21338;

    // Generator state loaded from the reset seeds.
    localparam logic [LAG_W-1:0] LAG_A_RESET = 8'd103;
    localparam logic [LAG_W-1:0] LAG_B_RESET = 8'd110;
    localparam logic [LAG_W-1:0] LAG_C_RESET = 8'd127;
    localparam logic [LAG_W-1:0] CONG_RESET  = 8'd44;

    // A product taken mod 64 is at least 32 exactly when bit 5 is set.
    localparam int OUT_BIT = 5;

    // Register indexes on the configuration port.
    localparam logic REG_FIRST_SEED  = 1'b0;
    localparam logic REG_SECOND_SEED = 1'b1;

    // Phases of one modular operation on the shared multiplier.
    localparam logic [1:0] PH_MUL = 2'd0;
    localparam logic [1:0] PH_QUO = 2'd1;
    localparam logic [1:0] PH_REM = 2'd2;

endpackage

`default_nettype wire

// ----- src/rstg_if.sv -----
// Valid/ready channel interfaces of the seed table generator.
// Depends on rstg_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rstg_cmd_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface rstg_res_if;
    logic                          valid;
    logic                          ready;
    logic [rstg_pkg::INDEX_W-1:0]  word_index;
    logic [rstg_pkg::VALUE_W-1:0]  word_value;
    logic                          last_word;

    modport source (output valid, output word_index, output word_value, output last_word,
                    input ready);
    modport sink (input valid, input word_index, input word_value, input last_word,
                  output ready);
endinterface

`default_nettype wire

// ----- src/ranmar_seed_table_generator.sv -----
// Seed table generator for the Marsaglia-Zaman universal generator: sequencer and shared unit.
// Depends on rstg_pkg and on the channel interfaces in rstg_if.sv.
//
// Usage. Each beat on the cmd channel asks for the next word of the 97-word seed
// table and yields exactly one beat on the result channel carrying the word's
// position (1 to 97), the 24-bit fraction (first generated bit in the MSB) and a
// flag on word 97. After word 97 the position wraps to 1 and the generator runs on.
// A cmd beat with restart set first reloads the lagged values and the
// congruential value from the two seed registers and starts again at word 1.
// The seeds are written through the APB port (first_seed at 0x0, second_seed at
// 0x4); a new seed only takes effect at the next restart.
//
// Timing. All arithmetic runs through one 15x9 multiplier. Every modular product
// runs on it as a multiply, a reciprocal quotient and a remainder with one
// correction, and each generated bit takes two mod-179 products, one mod-169
// update and one product for the output bit. A word appears on the result
// channel once all its bits are generated, after the seed reload first when
// restart is set, and cmd is ready again in the same cycle. No new cmd beat is
// taken until the finished word has moved into the output register.
//
// The result sits in an output register, so the next cmd beat is taken while it
// waits; if the receiver still stalls when the following word is finished, the
// sequencer holds that word until the register frees. Reset loads the state from
// the reset seeds, clears the position and leaves both channels idle.
`timescale 1ns / 1ps
`default_nettype none

module ranmar_seed_table_generator #(
    parameter int WORD_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    rstg_cmd_if.sink                           cmd,
    rstg_res_if.source                         result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rstg_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [rstg_pkg::DATA_W-1:0]   pwdata,
    output logic      [rstg_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int ALIGN = rstg_pkg::VALUE_W - WORD_BITS;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD1 = 3'd1;
    localparam logic [2:0] ST_LOAD2 = 3'd2;
    localparam logic [2:0] ST_AB    = 3'd3;
    localparam logic [2:0] ST_RC    = 3'd4;
    localparam logic [2:0] ST_CONG  = 3'd5;
    localparam logic [2:0] ST_BIT   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    // Configuration registers.
    logic [rstg_pkg::SEED_W-1:0] first_seed_reg, first_seed_next;
    logic [rstg_pkg::SEED_W-1:0] second_seed_reg, second_seed_next;

    // Control and generator state.
    logic [2:0]                  state_reg, state_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [CNT_W-1:0]            bit_cnt_reg, bit_cnt_next;
    logic [rstg_pkg::LAG_W-1:0]  lag_a_reg, lag_a_next;
    logic [rstg_pkg::LAG_W-1:0]  lag_b_reg, lag_b_next;
    logic [rstg_pkg::LAG_W-1:0]  lag_c_reg, lag_c_next;
    logic [rstg_pkg::LAG_W-1:0]  cong_reg, cong_next;
    logic [rstg_pkg::INDEX_W-1:0] words_done_reg, words_done_next;
    logic                        out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [rstg_pkg::MULX_W-1:0] prod_reg, prod_next;
    logic [rstg_pkg::LAG_W-1:0]  quo_reg, quo_next;
    logic [rstg_pkg::LAG_W-1:0]  tmp_reg, tmp_next;
    logic [rstg_pkg::VALUE_W-1:0] word_reg, word_next;
    logic [rstg_pkg::INDEX_W-1:0] out_index_reg, out_index_next;
    logic [rstg_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic                        out_last_reg, out_last_next;

    // Combinational signals.
    logic                        cfg_wr;
    logic                        reg_sel;
    logic                        seeds_ok;
    logic [rstg_pkg::SEED_W-1:0] seed1_eff;
    logic [rstg_pkg::SEED_W-1:0] seed2_eff;
    logic [rstg_pkg::MULX_W-1:0] op_x;
    logic [rstg_pkg::MULY_W-1:0] op_y;
    logic                        op_add;
    logic [rstg_pkg::LAG_W-1:0]  modulus;
    logic [rstg_pkg::MULY_W-1:0] recip;
    logic [rstg_pkg::MULX_W-1:0] mul_x;
    logic [rstg_pkg::MULY_W-1:0] mul_y;
    logic [rstg_pkg::MULP_W-1:0] mul_p;
    logic [rstg_pkg::MULX_W-1:0] diff_full;
    logic [8:0]                  diff9;
    logic [8:0]                  rem9;
    logic                        fix;
    logic [rstg_pkg::LAG_W-1:0]  rem_val;
    logic [rstg_pkg::LAG_W-1:0]  quo_val;
    logic                        rem_done;
    logic                        cmd_fire;
    logic                        out_load;
    logic [rstg_pkg::INDEX_W-1:0] wd_base;
    logic [rstg_pkg::INDEX_W-1:0] pos;

    // ------------------------------------------------------------------
    // APB configuration port. Only the register-select address bit is
    // decoded, so every write lands in one of the two seed registers.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_sel = paddr[rstg_pkg::ADDR_W-1];

    always_comb
    begin
        first_seed_next  = first_seed_reg;
        second_seed_next = second_seed_reg;
        unique case (reg_sel)
            rstg_pkg::REG_FIRST_SEED:
            begin
                prdata = {{(rstg_pkg::DATA_W - rstg_pkg::SEED_W){1'b0}}, first_seed_reg};
                if (cfg_wr)
                begin
                    first_seed_next = pwdata[rstg_pkg::SEED_W-1:0];
                end
            end
            rstg_pkg::REG_SECOND_SEED:
            begin
                prdata = {{(rstg_pkg::DATA_W - rstg_pkg::SEED_W){1'b0}}, second_seed_reg};
                if (cfg_wr)
                begin
                    second_seed_next = pwdata[rstg_pkg::SEED_W-1:0];
                end
            end
        endcase
    end

    // An out-of-range seed in either register swaps in the fallback pair.
    assign seeds_ok  = (first_seed_reg <= rstg_pkg::S1_MAX) &&
                       (second_seed_reg <= rstg_pkg::S2_MAX);
    assign seed1_eff = seeds_ok ? first_seed_reg : rstg_pkg::S1_DEFAULT;
    assign seed2_eff = seeds_ok ? second_seed_reg : rstg_pkg::S2_DEFAULT;

    // ------------------------------------------------------------------
    // Operands of the current job. Loading divides a seed, which is the
    // same multiply-reduce sequence with the multiplier set to one.
    // ------------------------------------------------------------------
    always_comb
    begin
        op_x    = '0;
        op_y    = '0;
        op_add  = 1'b0;
        modulus = rstg_pkg::LAG_MOD;
        recip   = rstg_pkg::RECIP_179;
        unique case (state_reg)
            ST_LOAD1:
            begin
                op_x    = seed1_eff;
                op_y    = 9'd1;
                modulus = rstg_pkg::SEED1_DIV;
                recip   = rstg_pkg::RECIP_177;
            end
            ST_LOAD2:
            begin
                op_x    = seed2_eff;
                op_y    = 9'd1;
                modulus = rstg_pkg::SEED2_DIV;
                recip   = rstg_pkg::RECIP_169;
            end
            ST_AB:
            begin
                op_x = {7'd0, lag_a_reg};
                op_y = {1'b0, lag_b_reg};
            end
            ST_RC:
            begin
                op_x = {7'd0, tmp_reg};
                op_y = {1'b0, lag_c_reg};
            end
            ST_CONG:
            begin
                op_x    = {7'd0, cong_reg};
                op_y    = rstg_pkg::CONG_MUL;
                op_add  = 1'b1;
                modulus = rstg_pkg::CONG_MOD;
                recip   = rstg_pkg::RECIP_169;
            end
            ST_BIT:
            begin
                op_x = {7'd0, cong_reg};
                op_y = {1'b0, lag_c_reg};
            end
            ST_IDLE, ST_DONE:
            begin
                op_x = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // The shared multiplier. In the first phase it forms the product, in
    // the second the reciprocal quotient estimate, in the third the
    // quotient times the modulus, which is then taken off the product.
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (phase_reg)
            rstg_pkg::PH_MUL:
            begin
                mul_x = op_x;
                mul_y = op_y;
            end
            rstg_pkg::PH_QUO:
            begin
                mul_x = prod_reg;
                mul_y = recip;
            end
            rstg_pkg::PH_REM:
            begin
                mul_x = {7'd0, quo_reg};
                mul_y = {1'b0, modulus};
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    // The estimate is short by at most one, so the remainder is below twice
    // the modulus and one compare and subtract finishes it.
    assign diff_full = prod_reg - mul_p[rstg_pkg::MULX_W-1:0];
    assign diff9     = diff_full[8:0];
    assign fix       = diff9 >= {1'b0, modulus};
    assign rem9      = fix ? (diff9 - {1'b0, modulus}) : diff9;
    assign rem_val   = rem9[rstg_pkg::LAG_W-1:0];
    assign quo_val   = quo_reg + {7'd0, fix};

    // ------------------------------------------------------------------
    // Table position of the finished word.
    // ------------------------------------------------------------------
    assign wd_base = (words_done_reg >= rstg_pkg::TABLE_WORDS) ? '0 : words_done_reg;
    assign pos     = wd_base + 7'd1;

    assign cmd_fire  = cmd.valid & cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        lag_a_next      = lag_a_reg;
        lag_b_next      = lag_b_reg;
        lag_c_next      = lag_c_reg;
        cong_next       = cong_reg;
        words_done_next = words_done_reg;
        prod_next       = prod_reg;
        quo_next        = quo_reg;
        tmp_next        = tmp_reg;
        word_next       = word_reg;
        rem_done        = 1'b0;

        // Phase stepping for the jobs that run a full modular operation.
        if ((state_reg == ST_LOAD1) || (state_reg == ST_LOAD2) || (state_reg == ST_AB) ||
            (state_reg == ST_RC) || (state_reg == ST_CONG))
        begin
            unique case (phase_reg)
                rstg_pkg::PH_MUL:
                begin
                    prod_next  = mul_p[rstg_pkg::MULX_W-1:0] + {14'd0, op_add};
                    phase_next = rstg_pkg::PH_QUO;
                end
                rstg_pkg::PH_QUO:
                begin
                    quo_next   = mul_p[rstg_pkg::MULP_W-1:rstg_pkg::RECIP_SHIFT];
                    phase_next = rstg_pkg::PH_REM;
                end
                rstg_pkg::PH_REM:
                begin
                    rem_done   = 1'b1;
                    phase_next = rstg_pkg::PH_MUL;
                end
                default:
                begin
                    phase_next = rstg_pkg::PH_MUL;
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    phase_next   = rstg_pkg::PH_MUL;
                    bit_cnt_next = '0;
                    state_next   = cmd.restart ? ST_LOAD1 : ST_AB;
                end
            end
            ST_LOAD1:
            begin
                if (rem_done)
                begin
                    lag_a_next = quo_val + 8'd2;
                    lag_b_next = rem_val + 8'd2;
                    state_next = ST_LOAD2;
                end
            end
            ST_LOAD2:
            begin
                if (rem_done)
                begin
                    lag_c_next      = quo_val + 8'd1;
                    cong_next       = rem_val;
                    words_done_next = '0;
                    state_next      = ST_AB;
                end
            end
            ST_AB:
            begin
                if (rem_done)
                begin
                    tmp_next   = rem_val;
                    state_next = ST_RC;
                end
            end
            ST_RC:
            begin
                if (rem_done)
                begin
                    lag_a_next = lag_b_reg;
                    lag_b_next = lag_c_reg;
                    lag_c_next = rem_val;
                    state_next = ST_CONG;
                end
            end
            ST_CONG:
            begin
                if (rem_done)
                begin
                    cong_next  = rem_val;
                    state_next = ST_BIT;
                end
            end
            ST_BIT:
            begin
                word_next    = {word_reg[rstg_pkg::VALUE_W-2:0], mul_p[rstg_pkg::OUT_BIT]};
                bit_cnt_next = bit_cnt_reg + CNT_W'(1);
                if (bit_cnt_reg == CNT_W'(WORD_BITS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_AB;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    words_done_next = (pos >= rstg_pkg::TABLE_WORDS) ? '0 : pos;
                    state_next      = ST_IDLE;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register. Bits left of the generated ones are shifted out so
    // that the first bit lands in the MSB and the bits below the generated ones are zero.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_index_next = pos;
            out_value_next = word_reg << ALIGN;
            out_last_next  = (pos == rstg_pkg::TABLE_WORDS);
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.word_index = out_index_reg;
    assign result.word_value = out_value_reg;
    assign result.last_word  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_seed_reg  <= rstg_pkg::S1_RESET;
            second_seed_reg <= rstg_pkg::S2_RESET;
            state_reg       <= ST_IDLE;
            phase_reg       <= rstg_pkg::PH_MUL;
            bit_cnt_reg     <= '0;
            lag_a_reg       <= rstg_pkg::LAG_A_RESET;
            lag_b_reg       <= rstg_pkg::LAG_B_RESET;
            lag_c_reg       <= rstg_pkg::LAG_C_RESET;
            cong_reg        <= rstg_pkg::CONG_RESET;
            words_done_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            first_seed_reg  <= first_seed_next;
            second_seed_reg <= second_seed_next;
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            bit_cnt_reg     <= bit_cnt_next;
            lag_a_reg       <= lag_a_next;
            lag_b_reg       <= lag_b_next;
            lag_c_reg       <= lag_c_next;
            cong_reg        <= cong_next;
            words_done_reg  <= words_done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        quo_reg       <= quo_next;
        tmp_reg       <= tmp_next;
        word_reg      <= word_next;
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire

// ----- src/rstg_checker.sv -----
// Port-level checks for the seed table generator and the bind that attaches them.
// Depends on rstg_pkg and on ranmar_seed_table_generator.
`timescale 1ns / 1ps
`default_nettype none

module rstg_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cmd_valid,
    input wire logic                          cmd_ready,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic [rstg_pkg::INDEX_W-1:0]  word_index,
    input wire logic [rstg_pkg::VALUE_W-1:0]  word_value,
    input wire logic                          last_word
);

    // An accepted beat starts a word, so the block is busy right after a beat.
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("cmd ready right after an accepted beat");

    // A stalled result beat holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(word_index) && $stable(word_value) && $stable(last_word)))
        else $error("stalled result beat changed");

    // The end-of-table flag marks exactly the last position.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (last_word == (word_index == rstg_pkg::TABLE_WORDS)))
        else $error("last_word does not match word_index");

    // Positions stay within the table.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((word_index != '0) && (word_index <= rstg_pkg::TABLE_WORDS)))
        else $error("word_index outside the table");

endmodule

bind ranmar_seed_table_generator rstg_checker u_rstg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .word_index (result.word_index),
    .word_value (result.word_value),
    .last_word  (result.last_word)
);

`default_nettype wire
